FILE: src/sde_pkg.sv
// Shared types for the sorted divisor enumerator: controller states and control/status structs.
package sde_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_EVAL,
      ST_EMIT_UP,
      ST_POP,
      ST_EMIT_DN
   } sde_state_type;

   typedef struct packed {
      logic load_n;
      logic start_div;
      logic div_step;
      logic inc_i;
      logic push;
      logic push_root;
      logic pop_rd;
      logic load_up;
      logic load_dn;
   } sde_cmd_type;

   typedef struct packed {
      logic req_zero;
      logic sq_lt;
      logic sq_eq;
      logic div_last;
      logic rem_zero;
      logic stack_empty;
      logic out_free;
   } sde_status_type;

endpackage

FILE: src/sde_if.sv
// Valid/ready channel interfaces for the request and response transactions.
interface sde_req_if #(parameter int VALUE_WIDTH = 12);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] n_value;

   modport source (output valid, output n_value, input ready);
   modport sink (input valid, input n_value, output ready);
endinterface

interface sde_rsp_if #(parameter int VALUE_WIDTH = 12);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] divisor;
   logic                   last;

   modport source (output valid, output divisor, output last, input ready);
   modport sink (input valid, input divisor, input last, output ready);
endinterface

FILE: src/sde_controller.sv
// Sequencer for the candidate scan, divider iterations and cofactor stack unwind.
module sde_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sde_pkg::sde_status_type status,
   output sde_pkg::sde_cmd_type    cmd
);
   import sde_pkg::*;

   sde_state_type state_ff;
   sde_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_n = 1'b1;
               if (!status.req_zero) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (status.sq_lt) begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIV;
            end else begin
               // root of a perfect square goes on the stack once
               cmd.push      = status.sq_eq;
               cmd.push_root = status.sq_eq;
               state_in      = ST_POP;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.rem_zero) begin
               state_in = ST_EMIT_UP;
            end else begin
               cmd.inc_i = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_EMIT_UP: begin
            if (status.out_free) begin
               cmd.load_up = 1'b1;
               cmd.push    = 1'b1;
               cmd.inc_i   = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_POP: begin
            cmd.pop_rd = 1'b1;
            state_in   = ST_EMIT_DN;
         end
         ST_EMIT_DN: begin
            if (status.out_free) begin
               cmd.load_dn = 1'b1;
               state_in    = status.stack_empty ? ST_IDLE : ST_POP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/sde_datapath.sv
// Candidate counter, bit-serial divider, cofactor stack memory and response register.
module sde_datapath #(
   parameter int VALUE_WIDTH = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [VALUE_WIDTH-1:0]  req_n_value,
   input  sde_pkg::sde_cmd_type    cmd,
   output sde_pkg::sde_status_type status,
   sde_rsp_if.source               rsp_if
);
   import sde_pkg::*;

   localparam int W     = VALUE_WIDTH;
   localparam int HALF  = (W + 1) / 2;
   localparam int CW    = HALF + 1;
   localparam int DEPTH = 1 << HALF;
   localparam int AW    = HALF;
   localparam int PW    = HALF + 1;
   localparam int SW    = $clog2(W);

   logic [W-1:0]    n_ff;
   logic [CW-1:0]   i_ff;
   logic [W-1:0]    rem_ff;
   logic [W-1:0]    quo_ff;
   logic [SW-1:0]   cnt_ff;
   logic [PW-1:0]   sp_ff;
   logic [W-1:0]    rd_ff;
   logic [W-1:0]    stack_mem [DEPTH];
   logic            rsp_valid_ff;
   logic [W-1:0]    divisor_ff;
   logic            last_ff;

   logic [2*CW-1:0] sq;
   logic [2*CW-1:0] n_ext;
   logic [W:0]      shifted;
   logic [W:0]      dvs;
   logic [W:0]      diff;
   logic            ge;
   logic [W-1:0]    rem_in;
   logic [W-1:0]    quo_in;
   logic [PW-1:0]   sp_dec;
   logic [W-1:0]    i_wide;
   logic [W-1:0]    push_data;
   logic            out_free;

   assign sq      = {{CW{1'b0}}, i_ff} * {{CW{1'b0}}, i_ff};
   assign n_ext   = {{(2*CW-W){1'b0}}, n_ff};
   assign i_wide  = {{(W-CW){1'b0}}, i_ff};
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign dvs     = {{(W+1-CW){1'b0}}, i_ff};
   assign ge      = shifted >= dvs;
   assign diff    = shifted - dvs;
   assign rem_in  = ge ? diff[W-1:0] : shifted[W-1:0];
   assign quo_in  = {quo_ff[W-2:0], ge};
   assign sp_dec  = sp_ff - 1'b1;
   assign push_data = cmd.push_root ? i_wide : quo_ff;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      status             = '0;
      status.req_zero    = req_n_value == '0;
      status.sq_lt       = sq < n_ext;
      status.sq_eq       = sq == n_ext;
      status.div_last    = cnt_ff == '0;
      status.rem_zero    = rem_ff == '0;
      status.stack_empty = sp_ff == '0;
      status.out_free    = out_free;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_n) begin
         n_ff <= req_n_value;
      end
      if (cmd.load_n) begin
         i_ff <= CW'(1);
      end else if (cmd.inc_i) begin
         i_ff <= i_ff + 1'b1;
      end
      if (cmd.start_div) begin
         rem_ff <= '0;
         quo_ff <= n_ff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.push) begin
         stack_mem[sp_ff[AW-1:0]] <= push_data;
      end
      if (cmd.pop_rd) begin
         rd_ff <= stack_mem[sp_dec[AW-1:0]];
      end
      if (cmd.load_up) begin
         divisor_ff <= i_wide;
         last_ff    <= 1'b0;
      end else if (cmd.load_dn) begin
         divisor_ff <= rd_ff;
         last_ff    <= sp_ff == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.start_div) begin
            cnt_ff <= SW'(W - 1);
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (cmd.load_n) begin
            sp_ff <= '0;
         end else if (cmd.push) begin
            sp_ff <= sp_ff + 1'b1;
         end else if (cmd.pop_rd) begin
            sp_ff <= sp_dec;
         end
         if (cmd.load_up || cmd.load_dn) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.divisor = divisor_ff;
   assign rsp_if.last    = last_ff;

endmodule

FILE: src/sorted_divisor_enumerator.sv
// Sorted divisor enumerator: emits every divisor of a request in ascending order.
// Each candidate i with i*i < n passes through check, bit-serial divide and evaluate,
// plus an emit step when it divides n; about ceil(sqrt(n)) candidates are tried.
// Each upper-half cofactor is then popped from the stack memory and presented.
// One request is handled at a time; a zero request completes with no responses.
// Synchronous active-high reset returns the sequencer to idle and drops response valid.
module sorted_divisor_enumerator #(
   parameter int VALUE_WIDTH = 12
) (
   input  logic      clock,
   input  logic      reset,
   sde_req_if.sink   req_if,
   sde_rsp_if.source rsp_if
);
   import sde_pkg::*;

   sde_cmd_type    cmd;
   sde_status_type status;
   logic           ctrl_req_ready;

   assign req_if.ready = ctrl_req_ready;

   sde_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ctrl_req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sde_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_n_value (req_if.n_value),
      .cmd         (cmd),
      .status      (status),
      .rsp_if      (rsp_if)
   );

endmodule
